// ----- hw/rtl/dssm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_pkg: shared types and constants
// Widths, operation and status codes, controller states and the command
// struct for the two-stack shared memory core.
// ----------------------------------------------------------------------------
package dssm_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 11;

  typedef enum logic [1:0] {
    OP_PUSH_FIRST  = 2'd0,
    OP_POP_FIRST   = 2'd1,
    OP_PUSH_SECOND = 2'd2,
    OP_POP_SECOND  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_RESPOND
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dssm_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dual_stack_shared_memory_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_core: two stacks in one shared store
// Usage:
//   Items: raise start with op and push_value; the item is taken at a clock
//   edge where start is high and busy is low. busy is high for one cycle.
//   Results: pop_value, status, first_empty and second_empty are valid for
//   exactly one cycle while done is high, in the respond state that follows
//   the access state. The receiver cannot stall; a result not taken is lost.
//   Overlap: a new item is not taken while busy is high, during the single
//   registered store access; the read data then shows with the result.
//   A new item may be started in the cycle its predecessor's result shows.
//   Configuration: cfg_data (capacity) is written when cfg_valid and
//   cfg_ready are high; cfg_ready follows !busy. A write empties both stacks.
//   Capacity 0 is taken as 1, above the store size as the store size.
//   Reset: synchronous rst empties both stacks and sets capacity to the full
//   store. Store contents are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [1:0]                  op,
  input  wire logic [dssm_pkg::DATA_W-1:0] push_value,
  output      logic                        done,
  output      logic [dssm_pkg::DATA_W-1:0] pop_value,
  output      logic [1:0]                  status,
  output      logic                        first_empty,
  output      logic                        second_empty,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [dssm_pkg::CAP_W-1:0]  cfg_data
);
  import dssm_pkg::*;

  dssm_cmd_t cmd;
  logic      cfg_we;

  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  dssm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  dssm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .op           (op),
    .push_value   (push_value),
    .pop_value    (pop_value),
    .status       (status),
    .first_empty  (first_empty),
    .second_empty (second_empty)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item taken but access cycle missing");

  a_done_after_access: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result shown without an access cycle");

  a_refused_value: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OVERFLOW) |-> (pop_value == '0))
    else $error("refused push gave a non-zero value");

  a_underflow_value: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_UNDERFLOW) |-> (pop_value == '1))
    else $error("underflow did not return all ones");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (first_empty && second_empty))
    else $error("capacity write did not empty the stacks");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/dssm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_ctrl: operation sequencer
// Takes an item, runs the memory access cycle, then presents the result.
// ----------------------------------------------------------------------------
module dssm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  output      logic              done,
  output      dssm_pkg::dssm_cmd_t cmd
);
  import dssm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    busy       = (state == S_ACCESS);
    done       = (state == S_RESPOND);
    cmd.load   = start && (state != S_ACCESS);
    cmd.exec   = (state == S_ACCESS);
    state_next = state;
    unique case (state)
      S_IDLE:    state_next = cmd.load ? S_ACCESS : S_IDLE;
      S_ACCESS:  state_next = S_RESPOND;
      // a new item may be taken while the result is shown
      S_RESPOND: state_next = cmd.load ? S_ACCESS : S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dssm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_datapath: counts, capacity register and shared store
// Stack one fills upwards from word 0, stack two downwards from capacity-1.
// ----------------------------------------------------------------------------
module dssm_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dssm_pkg::dssm_cmd_t         cmd,
  input  wire logic                        cfg_we,
  input  wire logic [dssm_pkg::CAP_W-1:0]  cfg_data,
  input  wire logic [1:0]                  op,
  input  wire logic [dssm_pkg::DATA_W-1:0] push_value,
  output      logic [dssm_pkg::DATA_W-1:0] pop_value,
  output      logic [1:0]                  status,
  output      logic                        first_empty,
  output      logic                        second_empty
);
  import dssm_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  op_t               op_q;
  logic [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]  first_count;
  logic [CNT_W-1:0]  second_count;
  logic [CNT_W-1:0]  capacity;
  status_t           status_q;
  logic              pop_ok;
  logic [DATA_W-1:0] rdata;

  logic [CNT_W:0]    used;
  logic              full;
  logic [CNT_W-1:0]  addr_wide;
  logic [ADDR_W-1:0] addr;
  logic              is_push;
  logic              can_pop;
  logic              wr_en;
  logic              rd_en;
  logic [CNT_W-1:0]  cap_clamped;

  always_comb begin
    used    = {1'b0, first_count} + {1'b0, second_count};
    full    = used >= {1'b0, capacity};
    is_push = (op_q == OP_PUSH_FIRST) || (op_q == OP_PUSH_SECOND);
    unique case (op_q)
      OP_PUSH_FIRST:  addr_wide = first_count;
      OP_POP_FIRST:   addr_wide = first_count - CNT_W'(1);
      OP_PUSH_SECOND: addr_wide = capacity - CNT_W'(1) - second_count;
      OP_POP_SECOND:  addr_wide = capacity - second_count;
      default:        addr_wide = first_count;
    endcase
    can_pop = (op_q == OP_POP_FIRST) ? (first_count != '0) : (second_count != '0);
    addr    = addr_wide[ADDR_W-1:0];
    wr_en   = cmd.exec && is_push && !full;
    rd_en   = cmd.exec && !is_push && can_pop;

    // zero reads as one, anything above the store size saturates
    if (cfg_data == '0) begin
      cap_clamped = CNT_W'(1);
    end else if ({{(CNT_W > CAP_W ? CNT_W - CAP_W : 0){1'b0}}, cfg_data} > CNT_W'(DEPTH)) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= value_q;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
    if (cmd.load) begin
      op_q    <= op_t'(op);
      value_q <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      capacity     <= CNT_W'(DEPTH);
      status_q     <= ST_DONE;
      pop_ok       <= 1'b0;
    end else if (cfg_we) begin
      capacity     <= cap_clamped;
      first_count  <= '0;
      second_count <= '0;
    end else if (cmd.exec) begin
      pop_ok <= rd_en;
      if (is_push) begin
        status_q <= full ? ST_OVERFLOW : ST_DONE;
      end else begin
        status_q <= can_pop ? ST_DONE : ST_UNDERFLOW;
      end
      priority if (wr_en && op_q == OP_PUSH_FIRST) begin
        first_count <= first_count + CNT_W'(1);
      end else if (wr_en) begin
        second_count <= second_count + CNT_W'(1);
      end else if (rd_en && op_q == OP_POP_FIRST) begin
        first_count <= first_count - CNT_W'(1);
      end else if (rd_en) begin
        second_count <= second_count - CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (pop_ok) begin
      pop_value = rdata;
    end else if (status_q == ST_UNDERFLOW) begin
      pop_value = '1;
    end else begin
      pop_value = '0;
    end
    status       = status_q;
    first_empty  = (first_count == '0);
    second_empty = (second_count == '0);
  end

endmodule
`default_nettype wire

// ----- tb/dual_stack_shared_memory_core_test.sv -----
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_core_test: two-stack shared store checker
// Drives push/pop items through the start/busy port and capacity writes
// through the cfg channel, keeps a mirror of both stacks and the shared
// store, and checks every done strobe against the oldest outstanding item.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_core_test;

  import dssm_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic [DATA_W-1:0] pop_value;
    status_t           status;
    logic              first_empty;
    logic              second_empty;
  } stack_outcome_t;

  // Mirror of both stacks; outcomes queued in acceptance order.
  class stack_pair_tracker;
    logic [DATA_W-1:0] mirror_words [DEPTH];
    int                low_count;
    int                high_count;
    int                cap;
    stack_outcome_t    awaited_outcomes [$];
    int                mismatches;
    int                results_seen;

    function new();
      low_count  = 0;
      high_count = 0;
      cap        = DEPTH;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void load_capacity(logic [CAP_W-1:0] v);
      if (v == 0)
        cap = 1;
      else if (v > DEPTH)
        cap = DEPTH;
      else
        cap = v;
      low_count  = 0;
      high_count = 0;
    endfunction

    function int pending();
      return awaited_outcomes.size();
    endfunction

    function void take_item(op_t cmd, logic [DATA_W-1:0] v);
      stack_outcome_t r;
      logic           full;
      r.pop_value = '0;
      r.status    = ST_DONE;
      full        = (low_count + high_count) >= cap;
      case (cmd)
        OP_PUSH_FIRST: begin
          if (full) begin
            r.status = ST_OVERFLOW;
          end else begin
            mirror_words[low_count] = v;
            low_count++;
          end
        end
        OP_POP_FIRST: begin
          if (low_count == 0) begin
            r.status    = ST_UNDERFLOW;
            r.pop_value = '1;
          end else begin
            low_count--;
            r.pop_value = mirror_words[low_count];
          end
        end
        OP_PUSH_SECOND: begin
          if (full) begin
            r.status = ST_OVERFLOW;
          end else begin
            mirror_words[cap - 1 - high_count] = v;
            high_count++;
          end
        end
        default: begin
          if (high_count == 0) begin
            r.status    = ST_UNDERFLOW;
            r.pop_value = '1;
          end else begin
            high_count--;
            r.pop_value = mirror_words[cap - 1 - high_count];
          end
        end
      endcase
      r.first_empty  = (low_count == 0);
      r.second_empty = (high_count == 0);
      awaited_outcomes.push_back(r);
    endfunction

    task report(string what);
      if (mismatches < 20)
        $display("mismatch at result %0d: %s", results_seen, what);
      mismatches++;
    endtask

    task check_result(logic [DATA_W-1:0] pv, logic [1:0] st, logic fe, logic se);
      stack_outcome_t w;
      results_seen++;
      if (awaited_outcomes.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      w = awaited_outcomes.pop_front();
      if (pv !== w.pop_value)
        report($sformatf("pop_value %h, expected %h", pv, w.pop_value));
      if (st !== w.status)
        report($sformatf("status %0d, expected %s", st, w.status.name()));
      if (fe !== w.first_empty)
        report($sformatf("first_empty %b, expected %b", fe, w.first_empty));
      if (se !== w.second_empty)
        report($sformatf("second_empty %b, expected %b", se, w.second_empty));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        op;
  logic [DATA_W-1:0] push_value;
  logic              done;
  logic [DATA_W-1:0] pop_value;
  logic [1:0]        status;
  logic              first_empty;
  logic              second_empty;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data;

  stack_pair_tracker tracker = new();
  int                quiet_cycles;

  dual_stack_shared_memory_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .push_value   (push_value),
    .done         (done),
    .pop_value    (pop_value),
    .status       (status),
    .first_empty  (first_empty),
    .second_empty (second_empty),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample everything on the edge, before any driven update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        tracker.load_capacity(cfg_data);
      if (start && !busy)
        tracker.take_item(op_t'(op), push_value);
      if (done)
        tracker.check_result(pop_value, status, first_empty, second_empty);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called just after an edge; returns at the acceptance edge with start high.
  task send_item(op_t cmd, logic [DATA_W-1:0] v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    op         <= cmd;
    push_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Only written with no item outstanding.
  task write_capacity(logic [CAP_W-1:0] v);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task run_random(int idle_pct, int item_count, logic [CAP_W-1:0] first_cap);
    int               sent;
    int               burst;
    int               push_bias;
    int               second_bias;
    int               pick;
    logic [CAP_W-1:0] cap_value;
    op_t              cmd;
    sent      = 0;
    cap_value = first_cap;
    while (sent < item_count) begin
      write_capacity(cap_value);
      burst       = $urandom_range(20, 80);
      push_bias   = $urandom_range(25, 80);
      second_bias = $urandom_range(20, 80);
      repeat (burst) begin
        if ($urandom_range(99) < push_bias)
          cmd = ($urandom_range(99) < second_bias) ? OP_PUSH_SECOND : OP_PUSH_FIRST;
        else
          cmd = ($urandom_range(99) < second_bias) ? OP_POP_SECOND : OP_POP_FIRST;
        send_item(cmd, $urandom(), idle_pct);
        sent++;
      end
      pick = $urandom_range(99);
      if (pick < 65)
        cap_value = $urandom_range(1, 16);
      else if (pick < 85)
        cap_value = $urandom_range(17, 64);
      else if (pick < 90)
        cap_value = 0;
      else if (pick < 95)
        cap_value = DEPTH;
      else
        cap_value = $urandom_range(DEPTH + 1, 2047);
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    op         = OP_PUSH_FIRST;
    push_value = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full-size store from reset: empty pops, extreme values, one of each op
    send_item(OP_POP_FIRST,   32'h0000_0000, 0);
    send_item(OP_POP_SECOND,  32'hFFFF_FFFF, 0);
    send_item(OP_PUSH_FIRST,  32'h7FFF_FFFF, 0);
    send_item(OP_PUSH_SECOND, 32'h8000_0000, 0);
    send_item(OP_POP_SECOND,  32'h0000_0000, 0);
    send_item(OP_POP_FIRST,   32'h0000_0000, 0);

    // zero capacity is taken as one word
    write_capacity(0);
    send_item(OP_PUSH_FIRST,  32'hFFFF_FFFF, 0);
    send_item(OP_PUSH_SECOND, 32'h1234_5678, 0);
    send_item(OP_PUSH_FIRST,  32'h0000_0001, 0);
    send_item(OP_POP_SECOND,  32'h0000_0000, 0);
    send_item(OP_POP_FIRST,   32'h0000_0000, 0);

    // capacity write while both stacks hold data empties them
    write_capacity(2);
    send_item(OP_PUSH_SECOND, 32'h5555_5555, 0);
    send_item(OP_PUSH_FIRST,  32'hAAAA_AAAA, 0);
    write_capacity(2);
    send_item(OP_POP_FIRST,   32'h0000_0000, 0);
    send_item(OP_PUSH_SECOND, 32'h0000_0000, 0);
    send_item(OP_PUSH_SECOND, 32'hAAAA_AAAA, 0);
    send_item(OP_PUSH_FIRST,  32'h5555_5555, 0);
    send_item(OP_POP_SECOND,  32'h0000_0000, 0);
    send_item(OP_POP_SECOND,  32'h0000_0000, 0);
    send_item(OP_POP_SECOND,  32'h0000_0000, 0);

    run_random(13, 600, 11'd2047);
    run_random(78, 600, DEPTH + 1);
    run_random(0,  600, DEPTH - 1);

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dssm_pkg.sv
hw/rtl/dssm_ctrl.sv
hw/rtl/dssm_datapath.sv
hw/rtl/dual_stack_shared_memory_core.sv
tb/dual_stack_shared_memory_core_test.sv
